### rtl/cove_pkg.sv
// Package for the option value extractor: result kinds, scan phases,
// configuration register indexes and sizes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cove_pkg;

	localparam int MAX_NAME_BYTES = 32;
	localparam int NAME_WORDS     = 4;
	localparam int WORD_BITS      = 64;
	localparam int LEN_BITS       = 6;
	localparam int IDX_BITS       = 5;
	localparam int CFG_IDX_BITS   = 3;

	localparam logic [CFG_IDX_BITS-1:0] CFG_NAME_LENGTH = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_NAME_WORD_0 = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_NAME_WORD_1 = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_NAME_WORD_2 = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_NAME_WORD_3 = 3'd4;

	localparam logic [7:0] CHR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHR_EQUALS  = 8'h3D;
	localparam logic [7:0] CHR_SPACE   = 8'h20;
	localparam logic [7:0] CHR_TAB     = 8'h09;
	localparam logic [7:0] CHR_CR      = 8'h0D;

	typedef enum logic [2:0] {
		KIND_BYTE      = 3'd0,
		KIND_DONE      = 3'd1,
		KIND_NOT_FOUND = 3'd2,
		KIND_EOL_NAME  = 3'd3,
		KIND_NO_EQ     = 3'd4,
		KIND_EOL_EQ    = 3'd5,
		KIND_UNTERM    = 3'd6
	} kind_t;

	typedef enum logic [5:0] {
		PH_MATCH      = 6'b000001,
		PH_SKIP_LINE  = 6'b000010,
		PH_AFTER_NAME = 6'b000100,
		PH_AFTER_EQ   = 6'b001000,
		PH_VALUE      = 6'b010000,
		PH_DONE       = 6'b100000
	} phase_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data_byte;
		logic [31:0] line_number;
		logic        last;
	} result_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == CHR_SPACE) || ((b >= CHR_TAB) && (b <= CHR_CR));
	endfunction

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

endpackage

`default_nettype wire

### rtl/config_option_value_extractor.sv
// Option value extractor top level: input register, scan logic, result register.
// Depends on cove_pkg.
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  input   | in_valid, in_ready, in_byte, is_end              | in
//  result  | out_valid, out_ready, kind, data_byte,           | out
//          | line_number, last                                |
//  config  | cfg_wr_en, cfg_index, cfg_data                   | in
//
// One word per cycle while results are taken; an accepted word moves from the input
// register through the scan logic into the result register.
// Reset arms the scan (matching at line 1) and clears the name registers.
// A held result stalls the input register, which in turn drops in_ready.
`timescale 1ns / 1ps
`default_nettype none

module config_option_value_extractor (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wr_en,
	input  wire logic [cove_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [cove_pkg::WORD_BITS-1:0]     cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [7:0]                         in_byte,
	input  wire logic                               is_end,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [2:0]                              kind,
	output logic [7:0]                              data_byte,
	output logic [31:0]                             line_number,
	output logic                                    last
);

	// configuration
	logic [cove_pkg::LEN_BITS-1:0]                            name_length_q;
	logic [cove_pkg::NAME_WORDS*cove_pkg::WORD_BITS-1:0]      name_bytes_q;

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        end_s1;

	// scan state
	cove_pkg::phase_t              phase_q, phase_d;
	logic [cove_pkg::LEN_BITS-1:0] match_index_q, match_index_d;
	logic [31:0]                   line_count_q, line_count_d;
	logic [31:0]                   found_line_q, found_line_d;
	logic [7:0]                    delimiter_q, delimiter_d;

	// result register
	logic                 out_valid_q;
	cove_pkg::result_t    res_q, res_d;
	logic                 emit;
	logic                 advance;

	logic [cove_pkg::LEN_BITS-1:0] len_eff;
	logic [7:0]                    name_byte;
	logic                          is_nl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_length_q <= '0;
			name_bytes_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				cove_pkg::CFG_NAME_LENGTH: name_length_q <= cfg_data[cove_pkg::LEN_BITS-1:0];
				cove_pkg::CFG_NAME_WORD_0: name_bytes_q[0*64 +: 64] <= cfg_data;
				cove_pkg::CFG_NAME_WORD_1: name_bytes_q[1*64 +: 64] <= cfg_data;
				cove_pkg::CFG_NAME_WORD_2: name_bytes_q[2*64 +: 64] <= cfg_data;
				cove_pkg::CFG_NAME_WORD_3: name_bytes_q[3*64 +: 64] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign len_eff = (name_length_q > cove_pkg::LEN_BITS'(cove_pkg::MAX_NAME_BYTES))
		? cove_pkg::LEN_BITS'(cove_pkg::MAX_NAME_BYTES) : name_length_q;
	assign name_byte = name_bytes_q[match_index_q[cove_pkg::IDX_BITS-1:0]*8 +: 8];
	assign is_nl     = (byte_s1 == cove_pkg::CHR_NEWLINE);

	// advance the input register whenever the result register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			end_s1  <= is_end;
		end
	end

	always_comb begin
		phase_d       = phase_q;
		match_index_d = match_index_q;
		line_count_d  = line_count_q;
		found_line_d  = found_line_q;
		delimiter_d   = delimiter_q;
		emit          = 1'b0;
		res_d         = '{kind: cove_pkg::KIND_BYTE, data_byte: 8'd0,
			line_number: found_line_q, last: 1'b1};

		if (end_s1) begin
			// re-arm on every end word
			phase_d       = cove_pkg::PH_MATCH;
			match_index_d = '0;
			line_count_d  = 32'd1;
			found_line_d  = '0;
			delimiter_d   = '0;
			unique case (phase_q)
				cove_pkg::PH_MATCH, cove_pkg::PH_SKIP_LINE: begin
					emit              = 1'b1;
					res_d.kind        = cove_pkg::KIND_NOT_FOUND;
					res_d.line_number = '0;
				end
				cove_pkg::PH_AFTER_NAME: begin
					emit       = 1'b1;
					res_d.kind = cove_pkg::KIND_EOL_NAME;
				end
				cove_pkg::PH_AFTER_EQ: begin
					emit       = 1'b1;
					res_d.kind = cove_pkg::KIND_EOL_EQ;
				end
				cove_pkg::PH_VALUE: begin
					emit       = 1'b1;
					res_d.kind = cove_pkg::KIND_UNTERM;
				end
				default: ;
			endcase
		end else begin
			unique case (phase_q)
				cove_pkg::PH_MATCH: begin
					if (match_index_q < len_eff) begin
						if (is_nl) begin
							line_count_d  = cove_pkg::sat_inc(line_count_q);
							match_index_d = '0;
						end else if (byte_s1 == name_byte) begin
							match_index_d = match_index_q + 1'b1;
						end else begin
							phase_d = cove_pkg::PH_SKIP_LINE;
						end
					end else if (byte_s1 == cove_pkg::CHR_EQUALS || cove_pkg::is_ws(byte_s1)) begin
						found_line_d = line_count_q;
						if (is_nl) begin
							phase_d           = cove_pkg::PH_DONE;
							emit              = 1'b1;
							res_d.kind        = cove_pkg::KIND_EOL_NAME;
							res_d.line_number = line_count_q;
						end else if (byte_s1 == cove_pkg::CHR_EQUALS) begin
							phase_d = cove_pkg::PH_AFTER_EQ;
						end else begin
							phase_d = cove_pkg::PH_AFTER_NAME;
						end
					end else begin
						phase_d = cove_pkg::PH_SKIP_LINE;
					end
				end
				cove_pkg::PH_SKIP_LINE: begin
					if (is_nl) begin
						line_count_d  = cove_pkg::sat_inc(line_count_q);
						match_index_d = '0;
						phase_d       = cove_pkg::PH_MATCH;
					end
				end
				cove_pkg::PH_AFTER_NAME: begin
					priority if (is_nl) begin
						phase_d    = cove_pkg::PH_DONE;
						emit       = 1'b1;
						res_d.kind = cove_pkg::KIND_EOL_NAME;
					end else if (cove_pkg::is_ws(byte_s1)) begin
					end else if (byte_s1 == cove_pkg::CHR_EQUALS) begin
						phase_d = cove_pkg::PH_AFTER_EQ;
					end else begin
						phase_d         = cove_pkg::PH_DONE;
						emit            = 1'b1;
						res_d.kind      = cove_pkg::KIND_NO_EQ;
						res_d.data_byte = byte_s1;
					end
				end
				cove_pkg::PH_AFTER_EQ: begin
					priority if (is_nl) begin
						phase_d    = cove_pkg::PH_DONE;
						emit       = 1'b1;
						res_d.kind = cove_pkg::KIND_EOL_EQ;
					end else if (!cove_pkg::is_ws(byte_s1)) begin
						delimiter_d = byte_s1;
						phase_d     = cove_pkg::PH_VALUE;
					end
				end
				cove_pkg::PH_VALUE: begin
					emit = 1'b1;
					if (byte_s1 == delimiter_q) begin
						phase_d    = cove_pkg::PH_DONE;
						res_d.kind = cove_pkg::KIND_DONE;
					end else begin
						if (is_nl) begin
							line_count_d = cove_pkg::sat_inc(line_count_q);
						end
						res_d.kind      = cove_pkg::KIND_BYTE;
						res_d.data_byte = byte_s1;
						res_d.last      = 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= cove_pkg::PH_MATCH;
			match_index_q <= '0;
			line_count_q  <= 32'd1;
			found_line_q  <= '0;
			delimiter_q   <= '0;
		end else if (advance) begin
			phase_q       <= phase_d;
			match_index_q <= match_index_d;
			line_count_q  <= line_count_d;
			found_line_q  <= found_line_d;
			delimiter_q   <= delimiter_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = res_q.kind;
	assign data_byte   = res_q.data_byte;
	assign line_number = res_q.line_number;
	assign last        = res_q.last;

endmodule

`default_nettype wire

### sim/config_option_value_extractor_tb.sv
// Self-checking testbench for the option value extractor: directed and random text
// streams, with random idling on both channels. Depends on cove_pkg and the top level.
`timescale 1ns / 1ps

module config_option_value_extractor_tb;
	import cove_pkg::*;

	localparam int CYCLE_LIMIT = 400_000;
	localparam int SETTLE      = 8;

	typedef struct {
		logic [7:0] b;
		logic       e;
	} text_word_t;

	logic                    clk        = 1'b0;
	logic                    arst_n     = 1'b0;
	logic                    cfg_wr_en  = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index  = '0;
	logic [WORD_BITS-1:0]    cfg_data   = '0;
	logic                    in_valid   = 1'b0;
	logic                    in_ready;
	logic [7:0]              in_byte    = '0;
	logic                    is_end     = 1'b0;
	logic                    out_valid;
	logic                    out_ready  = 1'b0;
	logic [2:0]              kind;
	logic [7:0]              data_byte;
	logic [31:0]             line_number;
	logic                    last;

	config_option_value_extractor i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.is_end      (is_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.data_byte   (data_byte),
		.line_number (line_number),
		.last        (last)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	text_word_t text_q[$];
	result_t    due_results[$];
	int         n_pushed  = 0;
	int         n_taken   = 0;
	int         n_items   = 0;
	int         n_err     = 0;
	int         cycles    = 0;
	bit         in_taken  = 0;
	bit         calm      = 0;
	int         in_gap    = 0;
	int         out_stall = 0;

	// scanner copy: configuration and state
	logic [LEN_BITS-1:0]  m_len = '0;
	logic [WORD_BITS-1:0] m_word [NAME_WORDS] = '{default: '0};
	phase_t               m_phase = PH_MATCH;
	int                   m_index = 0;
	logic [31:0]          m_line  = 32'd1;
	logic [31:0]          m_found = '0;
	logic [7:0]           m_delim = '0;

	function automatic bit is_space(input logic [7:0] b);
		return b == CHR_SPACE || (b >= CHR_TAB && b <= CHR_CR);
	endfunction

	function automatic int eff_len();
		return (m_len > MAX_NAME_BYTES) ? MAX_NAME_BYTES : int'(m_len);
	endfunction

	function automatic logic [7:0] name_at(input int i);
		return m_word[i / 8][(i % 8) * 8 +: 8];
	endfunction

	task automatic rearm();
		m_phase = PH_MATCH;
		m_index = 0;
		m_line  = 32'd1;
		m_found = '0;
		m_delim = '0;
	endtask

	task automatic next_line();
		if (m_line != 32'hFFFF_FFFF)
			m_line++;
		m_index = 0;
		m_phase = PH_MATCH;
	endtask

	// advance the scanner by one word; hit marks a result
	task automatic scan_word(input logic [7:0] b, input logic e, output bit hit,
			output result_t r);
		phase_t      p;
		logic [31:0] fl;
		int          len;
		hit = 0;
		r   = '0;
		len = eff_len();
		if (e) begin
			p  = m_phase;
			fl = m_found;
			rearm();
			hit           = 1;
			r.last        = 1'b1;
			r.line_number = fl;
			case (p)
				PH_MATCH, PH_SKIP_LINE: begin
					r.kind        = KIND_NOT_FOUND;
					r.line_number = '0;
				end
				PH_AFTER_NAME: r.kind = KIND_EOL_NAME;
				PH_AFTER_EQ:   r.kind = KIND_EOL_EQ;
				PH_VALUE:      r.kind = KIND_UNTERM;
				default:       hit = 0;
			endcase
			return;
		end
		case (m_phase)
			PH_MATCH: begin
				if (m_index < len) begin
					if (b == CHR_NEWLINE)
						next_line();
					else if (b == name_at(m_index))
						m_index++;
					else
						m_phase = PH_SKIP_LINE;
				end else if (b == CHR_EQUALS || is_space(b)) begin
					m_found = m_line;
					if (b == CHR_NEWLINE) begin
						m_phase = PH_DONE;
						hit     = 1;
						r.kind  = KIND_EOL_NAME;
					end else begin
						m_phase = (b == CHR_EQUALS) ? PH_AFTER_EQ : PH_AFTER_NAME;
					end
				end else begin
					m_phase = PH_SKIP_LINE;
				end
			end
			PH_SKIP_LINE: begin
				if (b == CHR_NEWLINE)
					next_line();
			end
			PH_AFTER_NAME: begin
				if (b == CHR_NEWLINE) begin
					m_phase = PH_DONE;
					hit     = 1;
					r.kind  = KIND_EOL_NAME;
				end else if (b == CHR_EQUALS) begin
					m_phase = PH_AFTER_EQ;
				end else if (!is_space(b)) begin
					m_phase     = PH_DONE;
					hit         = 1;
					r.kind      = KIND_NO_EQ;
					r.data_byte = b;
				end
			end
			PH_AFTER_EQ: begin
				if (b == CHR_NEWLINE) begin
					m_phase = PH_DONE;
					hit     = 1;
					r.kind  = KIND_EOL_EQ;
				end else if (!is_space(b)) begin
					m_delim = b;
					m_phase = PH_VALUE;
				end
			end
			PH_VALUE: begin
				hit = 1;
				if (b == m_delim) begin
					m_phase = PH_DONE;
					r.kind  = KIND_DONE;
				end else begin
					if (b == CHR_NEWLINE && m_line != 32'hFFFF_FFFF)
						m_line++;
					r.kind      = KIND_BYTE;
					r.data_byte = b;
				end
			end
			default: ;
		endcase
		r.line_number = m_found;
		r.last        = (r.kind != KIND_BYTE);
	endtask

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// input driver: hold the word until taken, then gap or advance
	always @(negedge clk) begin
		text_word_t w;
		if (arst_n) begin
			if ($urandom_range(0, 199) == 0)
				calm = !calm;
			if (in_valid && !in_taken) begin
				// hold
			end else if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (text_q.size() != 0) begin
				w = text_q.pop_front();
				in_byte  <= w.b;
				is_end   <= w.e;
				in_valid <= 1'b1;
				in_gap = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
			in_taken = 0;
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_stall > 0) begin
				out_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					out_stall = pick_gap();
			end
		end
	end

	// monitor: check results, then predict for the accepted word
	always @(posedge clk) begin
		bit      hit;
		result_t r;
		result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					n_err++;
					if (n_err <= 10)
						$display("unexpected result: kind %0d data %h line %0d last %b",
							kind, data_byte, line_number, last);
				end else begin
					want = due_results.pop_front();
					if (kind !== want.kind || data_byte !== want.data_byte ||
							line_number !== want.line_number || last !== want.last) begin
						n_err++;
						if (n_err <= 10)
							$display(
								"mismatch: kind %0d/%0d data %h/%h line %0d/%0d last %b/%b (exp/act)",
								want.kind, kind, want.data_byte, data_byte,
								want.line_number, line_number, want.last, last);
					end
				end
			end
			if (in_valid && in_ready) begin
				scan_word(in_byte, is_end, hit, r);
				if (hit)
					due_results.push_back(r);
				in_taken = 1;
				n_taken++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic push_word(input logic [7:0] b, input logic e);
		text_word_t w;
		w.b = b;
		w.e = e;
		text_q.push_back(w);
		n_pushed++;
		n_items++;
	endtask

	task automatic push_end();
		push_word(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic push_str(input string s);
		for (int k = 0; k < s.len(); k++)
			push_word(s[k], 1'b0);
	endtask

	function automatic logic [7:0] pick_ws();
		case ($urandom_range(0, 4))
			0:       return CHR_SPACE;
			1:       return CHR_TAB;
			2:       return 8'h0B;
			3:       return 8'h0C;
			default: return CHR_CR;
		endcase
	endfunction

	function automatic logic [7:0] pick_text();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c == CHR_NEWLINE);
		return c;
	endfunction

	function automatic logic [7:0] pick_hard();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (is_space(c) || c == CHR_EQUALS);
		return c;
	endfunction

	task automatic push_ws_run(input int lo);
		repeat ($urandom_range(lo, 3))
			push_word(pick_ws(), 1'b0);
	endtask

	// junk after a status is ignored, so it stays out of the item count
	task automatic push_tail();
		text_word_t w;
		repeat ($urandom_range(0, 3)) begin
			w.b = 8'($urandom_range(0, 255));
			w.e = 1'b0;
			text_q.push_back(w);
			n_pushed++;
		end
		push_end();
	endtask

	task automatic push_other_line();
		int len;
		int p;
		len = eff_len();
		case ($urandom_range(0, 3))
			0: ;
			1: repeat ($urandom_range(1, 8)) push_word(pick_text(), 1'b0);
			2: begin
				p = (len > 0) ? $urandom_range(0, len - 1) : 0;
				for (int k = 0; k < p; k++)
					push_word(name_at(k), 1'b0);
				push_word(pick_text(), 1'b0);
				repeat ($urandom_range(0, 4)) push_word(pick_text(), 1'b0);
			end
			default: begin
				for (int k = 0; k < len; k++)
					push_word(name_at(k), 1'b0);
				push_word(pick_hard(), 1'b0);
				repeat ($urandom_range(0, 4)) push_word(pick_text(), 1'b0);
			end
		endcase
		push_word(CHR_NEWLINE, 1'b0);
	endtask

	// one search: a few other lines, then noise, an end, or a sound or broken option line
	task automatic push_search();
		int         sel;
		int         len;
		logic [7:0] d;
		logic [7:0] c;
		len = eff_len();
		sel = $urandom_range(0, 99);
		repeat ($urandom_range(0, 3)) push_other_line();
		if (sel < 8) begin
			repeat ($urandom_range(1, 20)) push_word(8'($urandom_range(0, 255)), 1'b0);
			push_end();
			return;
		end
		if (sel < 13) begin
			push_end();
			return;
		end
		for (int k = 0; k < len; k++)
			push_word(name_at(k), 1'b0);
		if (sel < 21) begin
			push_ws_run(0);
			push_word(CHR_NEWLINE, 1'b0);
			push_tail();
			return;
		end
		if (sel < 27) begin
			push_ws_run(1);
			push_end();
			return;
		end
		if (sel < 34) begin
			push_ws_run(1);
			push_word(pick_hard(), 1'b0);
			push_tail();
			return;
		end
		push_ws_run(0);
		push_word(CHR_EQUALS, 1'b0);
		push_ws_run(0);
		if (sel < 41) begin
			push_word(CHR_NEWLINE, 1'b0);
			push_tail();
			return;
		end
		if (sel < 46) begin
			push_end();
			return;
		end
		do d = 8'($urandom_range(0, 255)); while (is_space(d));
		push_word(d, 1'b0);
		repeat ($urandom_range(0, 8)) begin
			if ($urandom_range(0, 5) == 0)
				c = CHR_NEWLINE;
			else
				do c = 8'($urandom_range(0, 255)); while (c == d);
			push_word(c, 1'b0);
		end
		if (sel < 54) begin
			push_end();
			return;
		end
		push_word(d, 1'b0);
		push_tail();
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [WORD_BITS-1:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		if (idx == CFG_NAME_LENGTH)
			m_len = value[LEN_BITS-1:0];
		else
			m_word[idx - CFG_NAME_WORD_0] = value;
	endtask

	task automatic write_name(input logic [WORD_BITS-1:0] len_word,
			input logic [WORD_BITS-1:0] w0, input logic [WORD_BITS-1:0] w1,
			input logic [WORD_BITS-1:0] w2, input logic [WORD_BITS-1:0] w3);
		write_reg(CFG_NAME_WORD_0, w0);
		write_reg(CFG_NAME_WORD_1, w1);
		write_reg(CFG_NAME_WORD_2, w2);
		write_reg(CFG_NAME_WORD_3, w3);
		write_reg(CFG_NAME_LENGTH, len_word);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic wait_idle();
		while (!(n_taken == n_pushed && due_results.size() == 0))
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	function automatic logic [WORD_BITS-1:0] rand_name_word();
		logic [WORD_BITS-1:0] w;
		w = {$urandom, $urandom};
		// a newline inside the name could never match; clear them
		for (int k = 0; k < 8; k++)
			if (w[k * 8 +: 8] == CHR_NEWLINE)
				w[k * 8 +: 8] = 8'h00;
		return w;
	endfunction

	initial begin
		int target;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// name "ab"
		write_name(64'd2, 64'h6261, '0, '0, '0);
		push_str("ab\n");
		push_end();
		push_str("x\nab=\n");
		push_end();
		push_str("ab\tq");
		push_end();
		push_str("ab='");
		push_word(8'h00, 1'b0);
		push_word(8'hFF, 1'b0);
		push_str("'");
		push_end();
		push_end();
		wait_idle();

		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: write_name(64'd0, rand_name_word(), rand_name_word(),
					rand_name_word(), rand_name_word());
				1: write_name(64'd1, rand_name_word(), '0, '0, '0);
				2: write_name(64'd32, '1, '1, '1, '1);
				// length above the limit clamps to the full name
				3: write_name('1, rand_name_word(), rand_name_word(),
					rand_name_word(), rand_name_word());
				4: write_name(64'd33, rand_name_word(), rand_name_word(),
					rand_name_word(), rand_name_word());
				5: write_name(64'd8, '0, '1, '1, '1);
				default: write_name(64'($urandom_range(0, 40)), rand_name_word(),
					rand_name_word(), rand_name_word(), rand_name_word());
			endcase
			target = n_items + 20;
			while (n_items < target)
				push_search();
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (due_results.size() != 0)
			n_err++;
		if (n_err == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### files.f
rtl/cove_pkg.sv
rtl/config_option_value_extractor.sv
sim/config_option_value_extractor_tb.sv
